>>> hw/rtl/ica_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ica_pkg
// Operation codes, status codes and unit handshake types of the integer ALU.
// ----------------------------------------------------------------------------
package ica_pkg;

    // operation codes (action field)
    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_POW = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ST_NEG_EXP   = 2'd2;
    localparam logic [1:0] ST_ZERO_ZERO = 2'd3;

    // multiplier digit: multiplier bits retired per cycle
    localparam int MUL_DIGIT = 8;

    // control into an iterative unit
    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    // status out of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/integer_calculator_alu.sv
// Add, subtract and codes 5-7 or flagged errors: straight from idle to the done state.
// Multiply: one 8-bit digit per multiplier cycle.
// Divide: one quotient bit per divider cycle.
// Power: a multiply for each set exponent bit and a square for each bit but the highest.
// One request at a time; s_ready is high only while the sequencer is idle.
// Reset: synchronous, active low aresetn; clears sequencer and output valid.
`default_nettype none
// ----------------------------------------------------------------------------
// integer_calculator_alu
// Signed integer ALU: add, subtract, multiply, truncating divide and integer
// power, wrapping modulo 2^DATA_WIDTH, with a status code per request.
// ----------------------------------------------------------------------------
module integer_calculator_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]  s_operand_a,
    input  wire logic signed [DATA_WIDTH-1:0]  s_operand_b,
    input  wire logic [2:0]                    s_action,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_result,
    output logic [1:0]                         m_status
);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_WAIT  = 3'd1;
    localparam logic [2:0] S_DIV_WAIT  = 3'd2;
    localparam logic [2:0] S_POW_CHECK = 3'd3;
    localparam logic [2:0] S_POW_ACC   = 3'd4;
    localparam logic [2:0] S_POW_SQ    = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]            state_reg, state_next;
    // power loop: accumulator, running square, remaining exponent
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] sq_reg, sq_next;
    logic [DATA_WIDTH-1:0] e_reg, e_next;
    // finished result, waiting for the output register
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic [1:0]            st_reg, st_next;
    logic                  negq_reg, negq_next;

    logic                  m_valid_reg;
    logic [DATA_WIDTH-1:0] m_result_reg;
    logic [1:0]            m_status_reg;

    logic [DATA_WIDTH-1:0] op_a, op_b, a_mag, b_mag;
    logic [DATA_WIDTH-1:0] e_shift;
    logic                  a_neg, b_neg, out_load;

    ica_pkg::unit_ctrl_t   mul_ctrl, div_ctrl;
    ica_pkg::unit_stat_t   mul_stat, div_stat;
    logic [DATA_WIDTH-1:0] mul_op_a, mul_op_b, mul_product, div_quotient;

    assign op_a    = s_operand_a;
    assign op_b    = s_operand_b;
    assign a_neg   = op_a[DATA_WIDTH-1];
    assign b_neg   = op_b[DATA_WIDTH-1];
    // magnitudes; the most negative value maps onto itself as unsigned
    assign a_mag   = a_neg ? ({DATA_WIDTH{1'b0}} - op_a) : op_a;
    assign b_mag   = b_neg ? ({DATA_WIDTH{1'b0}} - op_b) : op_b;
    assign e_shift = e_reg >> 1;

    ica_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .op_a    (mul_op_a),
        .op_b    (mul_op_b),
        .stat    (mul_stat),
        .product (mul_product)
    );

    ica_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (a_mag),
        .divisor  (b_mag),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        negq_next      = negq_reg;
        mul_ctrl.start = 1'b0;
        div_ctrl.start = 1'b0;
        mul_op_a       = op_a;
        mul_op_b       = op_b;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next   = '0;
                    st_next    = ica_pkg::ST_OK;
                    negq_next  = a_neg ^ b_neg;
                    state_next = S_DONE;
                    case (s_action)
                        ica_pkg::ACT_ADD: begin
                            res_next = op_a + op_b;
                        end
                        ica_pkg::ACT_SUB: begin
                            res_next = op_a - op_b;
                        end
                        ica_pkg::ACT_MUL: begin
                            mul_ctrl.start = 1'b1;
                            state_next     = S_MUL_WAIT;
                        end
                        ica_pkg::ACT_DIV: begin
                            if (op_b == '0) begin
                                st_next = ica_pkg::ST_DIV_ZERO;
                            end else begin
                                div_ctrl.start = 1'b1;
                                state_next     = S_DIV_WAIT;
                            end
                        end
                        ica_pkg::ACT_POW: begin
                            if (b_neg) begin
                                st_next = ica_pkg::ST_NEG_EXP;
                            end else if (op_b == '0 && op_a == '0) begin
                                st_next = ica_pkg::ST_ZERO_ZERO;
                            end else begin
                                acc_next   = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
                                sq_next    = op_a;
                                e_next     = op_b;
                                state_next = S_POW_CHECK;
                            end
                        end
                        default: begin
                            // unused codes give zero with status ok
                        end
                    endcase
                end
            end
            S_MUL_WAIT: begin
                if (mul_stat.done) begin
                    res_next   = mul_product;
                    state_next = S_DONE;
                end
            end
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    res_next   = negq_reg ? ({DATA_WIDTH{1'b0}} - div_quotient)
                                          : div_quotient;
                    state_next = S_DONE;
                end
            end
            S_POW_CHECK: begin
                if (e_reg == '0) begin
                    res_next   = acc_reg;
                    state_next = S_DONE;
                end else if (e_reg[0]) begin
                    mul_op_a       = acc_reg;
                    mul_op_b       = sq_reg;
                    mul_ctrl.start = 1'b1;
                    state_next     = S_POW_ACC;
                end else begin
                    // even bit: square only
                    mul_op_a       = sq_reg;
                    mul_op_b       = sq_reg;
                    mul_ctrl.start = 1'b1;
                    e_next         = e_shift;
                    state_next     = S_POW_SQ;
                end
            end
            S_POW_ACC: begin
                mul_op_a = sq_reg;
                mul_op_b = sq_reg;
                if (mul_stat.done) begin
                    acc_next = mul_product;
                    e_next   = e_shift;
                    if (e_shift == '0) begin
                        // last exponent bit, the final square is not needed
                        res_next   = mul_product;
                        state_next = S_DONE;
                    end else begin
                        mul_ctrl.start = 1'b1;
                        state_next     = S_POW_SQ;
                    end
                end
            end
            S_POW_SQ: begin
                if (mul_stat.done) begin
                    sq_next    = mul_product;
                    state_next = S_POW_CHECK;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        negq_reg <= negq_next;
    end

    // output register: takes the result once the previous one has gone
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_reg <= res_reg;
            m_status_reg <= st_reg;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_status = m_status_reg;

`ifndef ASSERT_OFF
    // multiplier finishes only while the sequencer waits on it
    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> (state_reg == S_MUL_WAIT || state_reg == S_POW_ACC ||
                           state_reg == S_POW_SQ))
        else $error("multiplier done outside a wait state");

    // divider finishes only in its wait state
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider done outside its wait state");

    // a taken request blocks the next one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after an accepted request");

    // flagged errors carry a zero result
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ica_pkg::ST_OK) |-> (m_result == '0))
        else $error("nonzero result with error status");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/ica_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ica_mul
// Iterative multiplier, low half of the product, one digit per cycle.
// ----------------------------------------------------------------------------
module ica_mul #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ica_pkg::unit_ctrl_t     ctrl,
    input  wire logic [DATA_WIDTH-1:0]   op_a,
    input  wire logic [DATA_WIDTH-1:0]   op_b,
    output ica_pkg::unit_stat_t          stat,
    output logic [DATA_WIDTH-1:0]        product
);

    localparam int DIGIT = ica_pkg::MUL_DIGIT;
    localparam int STEPS = (DATA_WIDTH + DIGIT - 1) / DIGIT;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DATA_WIDTH-1:0]       a_reg, b_reg, p_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic [DATA_WIDTH+DIGIT-1:0] pp;
    logic                        last;

    // digit partial product, only the low word is kept
    assign pp   = {{DIGIT{1'b0}}, a_reg} * {{DATA_WIDTH{1'b0}}, b_reg[DIGIT-1:0]};
    assign last = busy_reg && (cnt_reg == CW'(STEPS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctrl.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (last) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            a_reg <= op_a;
            b_reg <= op_b;
            p_reg <= '0;
        end else if (busy_reg && !last) begin
            p_reg <= p_reg + pp[DATA_WIDTH-1:0];
            a_reg <= a_reg << DIGIT;
            b_reg <= b_reg >> DIGIT;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = last;
    assign product   = p_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ica_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ica_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ica_div #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ica_pkg::unit_ctrl_t     ctrl,
    input  wire logic [DATA_WIDTH-1:0]   dividend,
    input  wire logic [DATA_WIDTH-1:0]   divisor,
    output ica_pkg::unit_stat_t          stat,
    output logic [DATA_WIDTH-1:0]        quotient
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] rem_reg, quo_reg, d_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  last;
    logic [DATA_WIDTH:0]   rem_ext, diff;

    // remainder stays below the divisor, so the shifted value fits the word
    assign rem_ext = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = rem_ext - {1'b0, d_reg};
    assign last    = busy_reg && (cnt_reg == CW'(DATA_WIDTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctrl.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (last) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            d_reg   <= divisor;
        end else if (busy_reg && !last) begin
            if (!diff[DATA_WIDTH]) begin
                rem_reg <= diff[DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= rem_ext[DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = last;
    assign quotient  = quo_reg;

endmodule
`default_nettype wire
